/* design/psl_pkg.sv */
// Shared types, token codes and keyword table for the Pascal-subset lexer.
package psl_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int KEYWORD_COUNT_DEF = 11;
  localparam int MAX_RESULTS       = 3;
  localparam int OUT_DEPTH         = 8;
  localparam int KW_TABLE_SIZE     = 11;

  // token kinds; keywords take their table index
  localparam logic [5:0] KIND_IDENT       = 6'd11;
  localparam logic [5:0] KIND_INT         = 6'd12;
  localparam logic [5:0] KIND_REAL        = 6'd13;
  localparam logic [5:0] KIND_EQ          = 6'd14;
  localparam logic [5:0] KIND_LE          = 6'd15;
  localparam logic [5:0] KIND_NE          = 6'd16;
  localparam logic [5:0] KIND_LT          = 6'd17;
  localparam logic [5:0] KIND_GE          = 6'd18;
  localparam logic [5:0] KIND_GT          = 6'd19;
  localparam logic [5:0] KIND_PLUS        = 6'd20;
  localparam logic [5:0] KIND_MINUS       = 6'd21;
  localparam logic [5:0] KIND_STAR        = 6'd22;
  localparam logic [5:0] KIND_SLASH       = 6'd23;
  localparam logic [5:0] KIND_ASSIGN      = 6'd24;
  localparam logic [5:0] KIND_COLON       = 6'd25;
  localparam logic [5:0] KIND_SEMI        = 6'd26;
  localparam logic [5:0] KIND_COMMA       = 6'd27;
  localparam logic [5:0] KIND_LPAREN      = 6'd28;
  localparam logic [5:0] KIND_RPAREN      = 6'd29;
  localparam logic [5:0] KIND_DOT         = 6'd30;
  localparam logic [5:0] KIND_ERR_COMMENT = 6'd31;
  localparam logic [5:0] KIND_ERR_REAL    = 6'd32;
  localparam logic [5:0] KIND_ERR_CHAR    = 6'd33;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_IDENT,
    MODE_INT,
    MODE_DOT,
    MODE_FRAC,
    MODE_LT,
    MODE_GT,
    MODE_COLON
  } mode_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [7:0]  length;
  } psl_result_t;

  typedef struct packed {
    psl_result_t res;
    logic        last;
  } psl_entry_t;

  // keyword text, first character in the low byte
  localparam logic [55:0] KW_TEXT [KW_TABLE_SIZE] = '{
    56'("margorp"), 56'("rav"), 56'("regetni"), 56'("laer"), 56'("nigeb"), 56'("dne"),
    56'("fi"), 56'("neht"), 56'("esle"), 56'("elihw"), 56'("od")
  };
  localparam logic [7:0] KW_LEN [KW_TABLE_SIZE] = '{
    8'd7, 8'd3, 8'd7, 8'd4, 8'd5, 8'd3, 8'd2, 8'd4, 8'd4, 8'd5, 8'd2
  };

  // parallel compare against every enabled keyword; lowest index wins
  function automatic logic [5:0] keyword_kind(input logic [55:0] prefix,
                                              input logic [7:0] count,
                                              input int unsigned kw_count);
    logic [5:0] kind;
    kind = KIND_IDENT;
    for (int i = KW_TABLE_SIZE - 1; i >= 0; i--) begin
      if (unsigned'(i) < kw_count && prefix == KW_TEXT[i] && count == KW_LEN[i]) begin
        kind = 6'(i);
      end
    end
    return kind;
  endfunction

endpackage

/* design/psl_scan.sv */
// Scanner state and per-byte token logic: one byte per cycle, up to three results.
module psl_scan import psl_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int KEYWORD_COUNT = KEYWORD_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [7:0]  in_byte,
  input  logic        in_eoi,
  output psl_result_t res [MAX_RESULTS],
  output logic [1:0]  res_count
);

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  mode_t mode, mode_next;
  logic [POSITION_BITS-1:0] line, line_next, col, col_next;
  logic [POSITION_BITS-1:0] start_line, start_line_next, start_col, start_col_next;
  logic [7:0]  count, count_next;
  logic [55:0] prefix, prefix_next;

  logic [POSITION_BITS-1:0] line_step, col_step, err_col;
  logic [7:0]  lower, add_val, count_add;
  logic [55:0] prefix_add;
  logic        is_letter, is_digit, pair_hit, absorb, to_idle;
  logic [5:0]  pair_kind;

  psl_result_t p0, p1, idle_res;
  logic        p0v, p1v, iv;
  logic        idle_single, idle_quiet;
  logic [5:0]  idle_kind;

  function automatic logic [15:0] pos_out(input logic [POSITION_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (|w[31:16]) ? 16'hFFFF : w[15:0];
  endfunction

  // saturating counters
  assign line_step = (&line) ? line : line + 1'b1;
  assign col_step  = (&col) ? col : col + 1'b1;
  assign err_col   = in_eoi ? col : col_step;

  assign lower     = in_byte | 8'h20;
  assign is_letter = (lower >= 8'h61) && (lower <= 8'h7A);
  assign is_digit  = (in_byte >= 8'h30) && (in_byte <= 8'h39);

  assign add_val   = (mode == MODE_IDENT && is_letter) ? lower : in_byte;
  assign count_add = (&count) ? count : count + 1'b1;
  always_comb begin
    prefix_add = prefix;
    for (int j = 0; j < 7; j++) begin
      if (count == 8'(j)) prefix_add[8*j +: 8] = add_val;
    end
  end

  // second byte of a two-character operator
  always_comb begin
    pair_hit  = 1'b0;
    pair_kind = KIND_EQ;
    if (!in_eoi) begin
      if (mode == MODE_LT && in_byte == CH_EQ) begin
        pair_hit  = 1'b1;
        pair_kind = KIND_LE;
      end else if (mode == MODE_LT && in_byte == CH_GT) begin
        pair_hit  = 1'b1;
        pair_kind = KIND_NE;
      end else if (mode == MODE_GT && in_byte == CH_EQ) begin
        pair_hit  = 1'b1;
        pair_kind = KIND_GE;
      end else if (mode == MODE_COLON && in_byte == CH_EQ) begin
        pair_hit  = 1'b1;
        pair_kind = KIND_ASSIGN;
      end
    end
  end

  // byte taken by the pending lexeme or comment; otherwise it is rescanned from idle
  assign absorb = !in_eoi && ((mode == MODE_COMMENT) ||
                  (mode == MODE_IDENT && (is_letter || is_digit)) ||
                  (mode == MODE_INT && (is_digit || in_byte == CH_DOT)) ||
                  ((mode == MODE_DOT || mode == MODE_FRAC) && is_digit) ||
                  pair_hit);
  assign to_idle = !in_eoi && !absorb;

  // next state
  always_comb begin
    mode_next       = mode;
    line_next       = line;
    col_next        = col;
    start_line_next = start_line;
    start_col_next  = start_col;
    count_next      = count;
    prefix_next     = prefix;
    if (in_eoi) begin
      mode_next = MODE_IDLE;
    end else if (absorb) begin
      col_next = col_step;
      unique case (mode)
        MODE_COMMENT: begin
          if (in_byte == CH_RBRACE) begin
            mode_next = MODE_IDLE;
          end else if (in_byte == CH_LF) begin
            line_next = line_step;
            col_next  = '0;
          end
        end
        MODE_IDENT, MODE_FRAC: begin
          prefix_next = prefix_add;
          count_next  = count_add;
        end
        MODE_INT: begin
          prefix_next = prefix_add;
          count_next  = count_add;
          if (in_byte == CH_DOT) mode_next = MODE_DOT;
        end
        MODE_DOT: begin
          prefix_next = prefix_add;
          count_next  = count_add;
          mode_next   = MODE_FRAC;
        end
        MODE_LT, MODE_GT, MODE_COLON: begin
          count_next = 8'd2;
          mode_next  = MODE_IDLE;
        end
        MODE_IDLE: ;
        default: ;
      endcase
    end else begin
      col_next  = col_step;
      mode_next = MODE_IDLE;
      priority if (in_byte == CH_LF) begin
        line_next = line_step;
        col_next  = '0;
      end else if (in_byte == CH_LBRACE) begin
        mode_next = MODE_COMMENT;
      end else if (is_letter || is_digit || in_byte == CH_LT || in_byte == CH_GT ||
                   in_byte == CH_COLON) begin
        start_line_next = line;
        start_col_next  = col_step;
        count_next      = 8'd1;
        prefix_next     = '0;
        if (is_letter) begin
          mode_next   = MODE_IDENT;
          prefix_next = {48'd0, lower};
        end else if (is_digit) begin
          mode_next = MODE_INT;
        end else if (in_byte == CH_LT) begin
          mode_next = MODE_LT;
        end else if (in_byte == CH_GT) begin
          mode_next = MODE_GT;
        end else begin
          mode_next = MODE_COLON;
        end
      end else begin
        mode_next = MODE_IDLE;
      end
    end
  end

  // results: pending token (and malformed-real pair), then the rescanned byte
  always_comb begin
    p0  = '{KIND_IDENT, pos_out(start_line), pos_out(start_col), count};
    p1  = '{KIND_REAL, pos_out(start_line), pos_out(start_col), count};
    p0v = pair_hit || (!absorb && mode != MODE_IDLE);
    p1v = !absorb && mode == MODE_DOT;
    if (pair_hit) begin
      p0 = '{pair_kind, pos_out(start_line), pos_out(start_col), 8'd2};
    end else begin
      unique case (mode)
        MODE_COMMENT: p0 = '{KIND_ERR_COMMENT, pos_out(line), pos_out(err_col), 8'd0};
        MODE_IDENT:   p0.kind = keyword_kind(prefix, count, KEYWORD_COUNT);
        MODE_INT:     p0.kind = KIND_INT;
        MODE_DOT:     p0 = '{KIND_ERR_REAL, pos_out(line), pos_out(err_col), 8'd0};
        MODE_FRAC:    p0.kind = KIND_REAL;
        MODE_LT:      p0.kind = KIND_LT;
        MODE_GT:      p0.kind = KIND_GT;
        MODE_COLON:   p0.kind = KIND_COLON;
        MODE_IDLE:    ;
        default:      ;
      endcase
    end
  end

  always_comb begin
    idle_single = 1'b1;
    idle_kind   = KIND_ERR_CHAR;
    unique case (in_byte)
      CH_EQ:     idle_kind = KIND_EQ;
      CH_PLUS:   idle_kind = KIND_PLUS;
      CH_MINUS:  idle_kind = KIND_MINUS;
      CH_STAR:   idle_kind = KIND_STAR;
      CH_SLASH:  idle_kind = KIND_SLASH;
      CH_SEMI:   idle_kind = KIND_SEMI;
      CH_COMMA:  idle_kind = KIND_COMMA;
      CH_LPAREN: idle_kind = KIND_LPAREN;
      CH_RPAREN: idle_kind = KIND_RPAREN;
      CH_DOT:    idle_kind = KIND_DOT;
      default:   idle_single = 1'b0;
    endcase
    idle_quiet = in_byte == CH_SPACE || in_byte == CH_TAB || in_byte == CH_LF ||
                 in_byte == CH_LBRACE || in_byte == CH_LT || in_byte == CH_GT ||
                 in_byte == CH_COLON || is_letter || is_digit;
    iv       = to_idle && !idle_quiet;
    idle_res = '{idle_kind, pos_out(line), pos_out(col_step), {7'd0, idle_single}};
  end

  // pack results in order
  assign res[0]    = p0v ? p0 : idle_res;
  assign res[1]    = p1v ? p1 : idle_res;
  assign res[2]    = idle_res;
  assign res_count = 2'(p0v) + 2'(p1v) + 2'(iv);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      line       <= POSITION_BITS'(1);
      col        <= '0;
      start_line <= '0;
      start_col  <= '0;
      count      <= '0;
      prefix     <= '0;
    end else if (in_valid) begin
      mode       <= mode_next;
      line       <= line_next;
      col        <= col_next;
      start_line <= start_line_next;
      start_col  <= start_col_next;
      count      <= count_next;
      prefix     <= prefix_next;
    end
  end

`ifndef ASSERT_OFF
  a_eoi_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_eoi) |=> mode == MODE_IDLE)
    else $error("mode not idle after end of input");

  a_newline_col: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_eoi && mode == MODE_IDLE && in_byte == CH_LF) |=> col == '0)
    else $error("column not cleared on newline");
`endif

endmodule

/* design/pascal_subset_lexer.sv */
// Pascal-subset lexer top level: byte stream in, token stream out.
// Tokens caused by a byte are written into the result queue at that byte's transaction.
// Throughput: one byte per cycle; results leave at one per cycle while m_axis_tready is
// high, through an eight-entry queue, and input stalls only while fewer than three
// entries are free (a byte can cause up to three results). Reset (rst, synchronous)
// clears the scanner to idle at line 1, column 0, and empties the result queue.
module pascal_subset_lexer import psl_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int KEYWORD_COUNT = KEYWORD_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] source_byte
  input  logic        s_axis_tuser,  // [0] end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // [5:0] token_kind, [21:6] token_line,
                                     // [37:22] token_column, [45:38] token_length, zero pad
  output logic        m_axis_tlast   // last_of_burst
);

  localparam int PTR_W = $clog2(OUT_DEPTH);

  psl_result_t res [MAX_RESULTS];
  logic [1:0]  res_count;
  logic        accept, pop;

  // result queue
  psl_entry_t       fifo [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   fill, fill_next;
  psl_entry_t       head;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign pop    = m_axis_tvalid && m_axis_tready;

  psl_scan #(
    .POSITION_BITS(POSITION_BITS),
    .KEYWORD_COUNT(KEYWORD_COUNT)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .in_byte  (s_axis_tdata),
    .in_eoi   (s_axis_tuser),
    .res      (res),
    .res_count(res_count)
  );

  // room for a whole burst before taking a byte; depends on registered fill only
  assign s_axis_tready = fill <= (PTR_W+1)'(OUT_DEPTH - MAX_RESULTS);

  assign fill_next = fill + (accept ? (PTR_W+1)'(res_count) : '0) - (PTR_W+1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (accept) wr_ptr <= wr_ptr + PTR_W'(res_count);
      if (pop)    rd_ptr <= rd_ptr + 1'b1;
      fill <= fill_next;
    end
  end

  // payload: burst written at consecutive slots, last one marked
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (accept && 2'(k) < res_count) begin
        fifo[PTR_W'(wr_ptr + PTR_W'(k))] <= '{res[k], 2'(k) == res_count - 2'd1};
      end
    end
  end

  assign head          = fifo[rd_ptr];
  assign m_axis_tvalid = fill != '0;
  assign m_axis_tdata  = {2'b00, head.res.length, head.res.column, head.res.line,
                          head.res.kind};
  assign m_axis_tlast  = head.last;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (PTR_W+1)'(OUT_DEPTH))
    else $error("result queue overflow");

  a_burst_shown: assert property (@(posedge clk) disable iff (rst)
    (accept && res_count != 2'd0) |=> m_axis_tvalid)
    else $error("results of a transaction not offered");
`endif

endmodule
